@@ hdl/ssih_pkg.sv @@
// Shared types and constants for the start/stop interval histogram.
// Depends on nothing; imported by the top level.
package ssih_pkg;

    localparam int TS_WIDTH    = 48;
    localparam int COUNT_WIDTH = 32;
    localparam int APB_AW      = 3;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    localparam logic CMD_EVENT = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic EV_START = 1'b0;
    localparam logic EV_STOP  = 1'b1;

    // Register index as seen in paddr[2].
    localparam logic REG_BIN_WIDTH   = 1'b0;
    localparam logic REG_BINS_IN_USE = 1'b1;

    localparam logic [31:0] BIN_WIDTH_RESET   = 32'd100;
    localparam logic [7:0]  BINS_IN_USE_RESET = 8'd100;

    typedef struct packed {
        logic                command;
        logic                is_stop;
        logic [TS_WIDTH-1:0] timestamp;
        logic [7:0]          bin_select;
    } t_in_word;

    typedef struct packed {
        logic                   matched;
        logic [TS_WIDTH-1:0]    interval;
        logic [7:0]             bin_number;
        logic [COUNT_WIDTH-1:0] count_value;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LIMIT,
        S_CMP,
        S_DIV,
        S_READ,
        S_UPDATE,
        S_PUSH
    } t_state;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
        sat_inc = (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

endpackage

@@ hdl/start_stop_interval_histogram.sv @@
// Start/stop interval histogram: top level with sequencer, shared compare/subtract
// unit, bin count memory and APB register port. Depends on ssih_pkg.
//
// Each input word steps through the sequencer and the block holds o_stall high until
// it is done. A start event, a stop before any start and a read of the overflow count
// or of a bin past it go straight to push; a bin read passes through read and update;
// a stop in overflow through limit and compare, and a stop in a bin through limit,
// compare, eight restoring division steps that share one compare/subtract unit, and
// the read-modify-write of the single-port bin memory. The result register lets a new
// word in while the previous result still waits. After reset the histogram reads as
// all zero at once; per-bin valid bits stand in for a clearing pass.
module start_stop_interval_histogram #(
    parameter int MAX_BINS   = 128,
    parameter int TIME_WIDTH = 48
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Event and read commands.
    input  logic                      i_valid,
    output logic                      o_stall,
    input  ssih_pkg::t_in_word        i_data,
    // Results.
    output logic                      o_valid,
    input  logic                      i_stall,
    output ssih_pkg::t_out_word       o_data,
    // Configuration.
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ssih_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import ssih_pkg::*;

    // Bin indexes come from 8-bit fields, so no more than 255 bins are reachable.
    localparam int DEPTH = (MAX_BINS > 255) ? 255 : MAX_BINS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = (TIME_WIDTH > 40) ? TIME_WIDTH : 40;
    localparam logic [7:0] BIN_CAP = 8'(DEPTH);

    t_state                 r_state, n_state;
    logic [TIME_WIDTH-1:0]  r_last_start, n_last_start;
    logic                   r_start_seen, n_start_seen;
    logic [31:0]            r_width;
    logic [7:0]             r_bins;
    logic [31:0]            r_op_width, n_op_width;
    logic [7:0]             r_nbins, n_nbins;
    logic [39:0]            r_limit, n_limit;
    logic [CW-1:0]          r_rem, n_rem;
    logic [2:0]             r_k, n_k;
    logic [7:0]             r_q, n_q;
    logic                   r_is_read, n_is_read;
    logic [AW-1:0]          r_addr, n_addr;
    t_out_word              r_res, n_res;
    t_out_word              r_out, n_out;
    logic                   r_out_valid, n_out_valid;
    logic [COUNT_WIDTH-1:0] r_ovf_count, n_ovf_count;

    logic [COUNT_WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0]       r_valid;
    logic [COUNT_WIDTH-1:0] r_rd_data;
    logic                   r_rd_valid;
    logic                   mem_we;
    logic [COUNT_WIDTH-1:0] mem_wdata;

    logic                   accept;
    logic                   out_take;
    logic                   cfg_write;
    logic [31:0]            eff_width;
    logic [7:0]             eff_bins;
    logic [TIME_WIDTH-1:0]  ts_t;
    logic [TIME_WIDTH-1:0]  diff;
    logic [CW-1:0]          cmp_b;
    logic [CW:0]            cmp_diff;
    logic                   cmp_ge;
    logic [COUNT_WIDTH-1:0] cur_count;

    assign o_stall   = (r_state != S_IDLE);
    assign accept    = i_valid && !o_stall;
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;
    assign out_take  = r_out_valid && !i_stall;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    assign eff_width = (r_width == '0) ? 32'd1 : r_width;
    always_comb begin
        eff_bins = (r_bins == '0) ? 8'd1 : r_bins;
        if (eff_bins > BIN_CAP) begin
            eff_bins = BIN_CAP;
        end
    end

    assign ts_t = TIME_WIDTH'(i_data.timestamp);
    assign diff = ts_t - r_last_start;

    // Shared unit: compares the remainder with the overflow limit or a shifted width.
    assign cmp_b    = (r_state == S_CMP) ? CW'(r_limit) : (CW'(r_op_width) << r_k);
    assign cmp_diff = {1'b0, r_rem} - {1'b0, cmp_b};
    assign cmp_ge   = !cmp_diff[CW];

    assign cur_count = r_rd_valid ? r_rd_data : '0;

    always_comb begin
        unique case (paddr[2])
            REG_BIN_WIDTH:   prdata = r_width;
            REG_BINS_IN_USE: prdata = {24'b0, r_bins};
            default:         prdata = '0;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_last_start = r_last_start;
        n_start_seen = r_start_seen;
        n_op_width   = r_op_width;
        n_nbins      = r_nbins;
        n_limit      = r_limit;
        n_rem        = r_rem;
        n_k          = r_k;
        n_q          = r_q;
        n_is_read    = r_is_read;
        n_addr       = r_addr;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = out_take ? 1'b0 : r_out_valid;
        n_ovf_count  = r_ovf_count;
        mem_we       = 1'b0;
        mem_wdata    = sat_inc(cur_count);

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res      = '0;
                    n_nbins    = eff_bins;
                    n_op_width = eff_width;
                    n_state    = S_PUSH;
                    if (i_data.command == CMD_READ) begin
                        n_res.bin_number = i_data.bin_select;
                        if (i_data.bin_select < eff_bins) begin
                            n_addr    = i_data.bin_select[AW-1:0];
                            n_is_read = 1'b1;
                            n_state   = S_READ;
                        end else if (i_data.bin_select == eff_bins) begin
                            n_res.count_value = r_ovf_count;
                        end
                    end else if (i_data.is_stop == EV_START) begin
                        n_last_start = ts_t;
                        n_start_seen = 1'b1;
                    end else if (r_start_seen) begin
                        n_is_read      = 1'b0;
                        n_rem          = CW'(diff);
                        n_res.matched  = 1'b1;
                        n_res.interval = TS_WIDTH'(diff);
                        n_state        = S_LIMIT;
                    end
                end
            end
            S_LIMIT: begin
                // Quotient reaches the bin count exactly when diff >= bins * width.
                n_limit = {8'b0, r_op_width} * {32'b0, r_nbins};
                n_state = S_CMP;
            end
            S_CMP: begin
                if (cmp_ge) begin
                    n_ovf_count      = sat_inc(r_ovf_count);
                    n_res.bin_number = r_nbins;
                    n_state          = S_PUSH;
                end else begin
                    n_k     = 3'd7;
                    n_q     = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // The quotient is below 256 here, so eight restoring steps suffice.
                if (cmp_ge) begin
                    n_rem = cmp_diff[CW-1:0];
                end
                n_q[r_k] = cmp_ge;
                if (r_k == 3'd0) begin
                    n_addr  = n_q[AW-1:0];
                    n_state = S_READ;
                end else begin
                    n_k = r_k - 3'd1;
                end
            end
            S_READ: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (r_is_read) begin
                    n_res.count_value = cur_count;
                end else begin
                    mem_we           = 1'b1;
                    n_res.bin_number = r_q;
                end
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (!r_out_valid || !i_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_last_start <= '0;
            r_start_seen <= 1'b0;
            r_out_valid  <= 1'b0;
            r_ovf_count  <= '0;
            r_width      <= BIN_WIDTH_RESET;
            r_bins       <= BINS_IN_USE_RESET;
            r_valid      <= '0;
        end else begin
            r_state      <= n_state;
            r_last_start <= n_last_start;
            r_start_seen <= n_start_seen;
            r_out_valid  <= n_out_valid;
            r_ovf_count  <= n_ovf_count;
            if (cfg_write) begin
                unique case (paddr[2])
                    REG_BIN_WIDTH:   r_width <= pwdata;
                    REG_BINS_IN_USE: r_bins  <= pwdata[7:0];
                    default:         r_width <= r_width;
                endcase
            end
            if (mem_we) begin
                r_valid[r_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op_width <= n_op_width;
        r_nbins    <= n_nbins;
        r_limit    <= n_limit;
        r_rem      <= n_rem;
        r_k        <= n_k;
        r_q        <= n_q;
        r_is_read  <= n_is_read;
        r_addr     <= n_addr;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    // Bin count memory: one port, read registered.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_addr] <= mem_wdata;
        end
        if (r_state == S_READ) begin
            r_rd_data  <= mem[r_addr];
            r_rd_valid <= r_valid[r_addr];
        end
    end

    a_matched_bin_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.matched) |-> (o_data.bin_number <= r_nbins))
        else $error("matched result names a bin past the overflow slot");

    a_matched_needs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.matched) |-> r_start_seen)
        else $error("stop matched although no start was seen");

    a_quotient_below_bins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ && !r_is_read) |-> (r_q < r_nbins))
        else $error("division produced a bin index at or past the bin count");

    a_remainder_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < (CW'(r_op_width) << (4'(r_k) + 4'd1))))
        else $error("division remainder out of range for the current step");

    a_unmatched_zero_interval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.matched) |-> (o_data.interval == '0))
        else $error("unmatched result carries a nonzero interval");

endmodule
